@@ rtl/lnpg_pkg.sv @@
// Package for the LFSR noise pixel generator: widths, codes, stage layout
// and the single-step register advance. No dependencies.
`default_nettype none

package lnpg_pkg;

  // Field and register widths
  localparam int unsigned SEED_W     = 32;
  localparam int unsigned PIX_W      = 31;
  localparam int unsigned DEPTH_W    = 5;
  localparam int unsigned LEVEL_W    = 17;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // Advances per pixel at most (5-bit count)
  localparam int unsigned MAX_ADV = 31;

  // Arithmetic widths
  localparam int unsigned GRP_N   = 4;              // partial sum groups
  localparam int unsigned GRP_LEN = 8;              // terms per group
  localparam int unsigned PSUM_W  = PIX_W + 3;      // sum of 8 terms
  localparam int unsigned SUM_W   = PIX_W + 5;      // sum of 31 terms
  localparam int unsigned GP_W    = LEVEL_W + SUM_W;
  localparam int unsigned OM_W    = LEVEL_W + PIX_W;
  localparam int unsigned NUM_W   = GP_W + 1;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned QUO_W   = 40;             // padded integer part
  localparam int unsigned DIV_ST  = 5;
  localparam int unsigned DIV_BITS = QUO_W / DIV_ST;

  // Pipeline layout: terms, group sums, sum, products, numerator,
  // divider stages, output register
  localparam int unsigned ST_DIV0 = 5;
  localparam int unsigned NUM_ST  = ST_DIV0 + DIV_ST + 1;

  // Feedback taps
  localparam logic [SEED_W-1:0] TAP_MASK = 32'h1d87_2b41;

  // Saturation limits per depth class
  localparam logic [PIX_W-1:0] LIM_D8   = 31'd255;
  localparam logic [PIX_W-1:0] LIM_D16  = 31'd65535;
  localparam logic [PIX_W-1:0] LIM_WIDE = 31'h7fff_ffff;

  // Commands
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIT_DEPTH    = 8'd0,
    CFG_GAIN_LEVEL   = 8'd1,
    CFG_OFFSET_LEVEL = 8'd2,
    CFG_MEAN_COUNT   = 8'd3
  } cfg_idx_e;

  // Masked register values, one per advance
  typedef logic [MAX_ADV-1:0][PIX_W-1:0] term_vec_t;

  // One register advance: shift left, fold in taps if zero or negative
  function automatic logic [SEED_W-1:0] lfsr_advance(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] t;
    t = {s[SEED_W-2:0], 1'b0};
    if (t[SEED_W-1] || (t == '0)) begin
      t = t ^ TAP_MASK;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

@@ rtl/lnpg_intf.sv @@
// Channel interfaces of the LFSR noise pixel generator: command input,
// pixel output and configuration write. Uses lnpg_pkg for widths.
`default_nettype none

// Command channel
interface lnpg_cmd_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [lnpg_pkg::SEED_W-1:0] seed_value;

  modport source (output valid, output command, output seed_value, input ready);
  modport sink   (input valid, input command, input seed_value, output ready);
endinterface

// Pixel channel
interface lnpg_pix_if;
  logic                       valid;
  logic                       ready;
  logic [lnpg_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

// Configuration write channel
interface lnpg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lnpg_pkg::CFG_IDX_W-1:0]  index;
  logic [lnpg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/lfsr_noise_pixel_generator.sv @@
// Top level of the LFSR noise pixel generator: configuration registers,
// state register and the result pipeline. Uses lnpg_pkg, lnpg_intf.sv
// and lnpg_lfsr_unroll.
`default_nettype none

// One command word is taken per clock cycle while the first stage is empty
// or draining. A load word sets the 32-bit noise register and yields no
// pixel; a pixel word advances the register mean_count times (zero counts
// as one) within its accept cycle and yields one pixel through registered
// stages in this order: the advance chain terms, the adder tree, the
// gain/offset products and the numerator, the division by mean_count
// (restoring, eight quotient bits per stage) and rounding to nearest-even
// and saturation. Each stage stalls only when the stage after it is full,
// so bubbles are squeezed out under backpressure. Configuration writes are
// taken every cycle and must only be issued while no pixel is in flight.
module lfsr_noise_pixel_generator (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lnpg_cmd_if.sink   cmd_i,
  lnpg_cfg_if.sink   cfg_i,
  lnpg_pix_if.source pix_o
);
  import lnpg_pkg::*;

  // Configuration and state registers
  logic [DEPTH_W-1:0] depth_q;
  logic [LEVEL_W-1:0] gain_q;
  logic [LEVEL_W-1:0] offset_q;
  logic [CNT_W-1:0]   mean_q;
  logic [SEED_W-1:0]  lfsr_q;
  logic [SEED_W-1:0]  lfsr_d;

  // Derived configuration
  logic [CNT_W-1:0] n_eff;
  logic [PIX_W-1:0] maxval;

  // Stage control
  logic [NUM_ST-1:0] vld_q;
  logic [NUM_ST-1:0] vld_d;
  logic [NUM_ST-1:0] ld;
  logic [NUM_ST:0]   rdy;
  logic              in_pix;
  logic              cmd_acc;

  // Stage payloads
  term_vec_t                     terms_d;
  term_vec_t                     terms_q;
  logic [GRP_N-1:0][PSUM_W-1:0]  psum_d;
  logic [GRP_N-1:0][PSUM_W-1:0]  psum_q;
  logic [SUM_W-1:0]              sum_d;
  logic [SUM_W-1:0]              sum_q;
  logic [GP_W-1:0]               gp_q;
  logic [OM_W-1:0]               om_q;
  logic [NUM_W-1:0]              num_d;
  logic [NUM_W-1:0]              num_q;
  logic [DIV_ST-1:0][QUO_W-1:0]  dword_d;
  logic [DIV_ST-1:0][QUO_W-1:0]  dword_q;
  logic [DIV_ST-1:0][CNT_W-1:0]  drem_d;
  logic [DIV_ST-1:0][CNT_W-1:0]  drem_q;
  logic [DIV_ST-1:0][FRAC_W-1:0] dfrac_q;
  logic [PIX_W-1:0]              pix_d;
  logic [PIX_W-1:0]              pix_q;
  logic [SEED_W-1:0]             lfsr_next;

  assign n_eff  = (mean_q == '0) ? CNT_W'(1) : mean_q;
  assign maxval = ~(LIM_WIDE << depth_q);

  // Configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= DEPTH_W'(8);
      gain_q   <= LEVEL_W'(65536);
      offset_q <= '0;
      mean_q   <= CNT_W'(1);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_BIT_DEPTH:    depth_q  <= cfg_i.data[DEPTH_W-1:0];
        CFG_GAIN_LEVEL:   gain_q   <= cfg_i.data[LEVEL_W-1:0];
        CFG_OFFSET_LEVEL: offset_q <= cfg_i.data[LEVEL_W-1:0];
        CFG_MEAN_COUNT:   mean_q   <= cfg_i.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance chain for the current register
  lnpg_lfsr_unroll u_unroll (
    .state_i (lfsr_q),
    .count_i (n_eff),
    .mask_i  (maxval),
    .terms_o (terms_d),
    .next_o  (lfsr_next)
  );

  // Stage handshake: a stage takes a word when empty or draining
  always_comb begin
    rdy[NUM_ST] = pix_o.ready;
    for (int k = NUM_ST - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    in_pix  = cmd_i.valid && (cmd_i.command == CMD_PIXEL);
    cmd_acc = cmd_i.valid && rdy[0];
    for (int k = 0; k < NUM_ST; k++) begin
      if (k == 0) begin
        ld[k] = in_pix && rdy[0];
      end else begin
        ld[k] = vld_q[k-1] && rdy[k];
      end
      vld_d[k] = ld[k] || (vld_q[k] && !rdy[k+1]);
    end
  end

  assign cmd_i.ready = rdy[0];

  // Noise register update on accepted words
  always_comb begin
    lfsr_d = lfsr_q;
    if (cmd_acc) begin
      if (cmd_i.command == CMD_PIXEL) begin
        lfsr_d = lfsr_next;
      end else begin
        lfsr_d = cmd_i.seed_value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= '0;
      vld_q  <= '0;
    end else begin
      lfsr_q <= lfsr_d;
      vld_q  <= vld_d;
    end
  end

  // Adder tree: groups of eight, then the four group sums
  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      psum_d[g] = '0;
      for (int j = 0; j < GRP_LEN; j++) begin
        if (g * GRP_LEN + j < MAX_ADV) begin
          psum_d[g] = psum_d[g] + PSUM_W'(terms_q[g*GRP_LEN+j]);
        end
      end
    end
    sum_d = '0;
    for (int g = 0; g < GRP_N; g++) begin
      sum_d = sum_d + SUM_W'(psum_q[g]);
    end
  end

  // Numerator: offset*maxval*n + gain*sum
  assign num_d = NUM_W'(om_q) * NUM_W'(n_eff) + NUM_W'(gp_q);

  // Restoring division of the integer part by n, eight bits per stage
  always_comb begin
    logic [QUO_W-1:0] w;
    logic [CNT_W:0]   r6;
    logic [CNT_W-1:0] r;
    for (int k = 0; k < DIV_ST; k++) begin
      if (k == 0) begin
        w = QUO_W'(num_q[NUM_W-1:FRAC_W]);
        r = '0;
      end else begin
        w = dword_q[k-1];
        r = drem_q[k-1];
      end
      for (int b = 0; b < DIV_BITS; b++) begin
        r6 = {r, w[QUO_W-1]};
        w  = {w[QUO_W-2:0], 1'b0};
        if (r6 >= {1'b0, n_eff}) begin
          r6   = r6 - {1'b0, n_eff};
          w[0] = 1'b1;
        end
        r = r6[CNT_W-1:0];
      end
      dword_d[k] = w;
      drem_d[k]  = r;
    end
  end

  // Round half to even, then saturate to the depth class
  always_comb begin
    logic [CNT_W+FRAC_W:0] twice_r;
    logic [CNT_W+FRAC_W:0] den;
    logic                  up;
    logic [QUO_W-1:0]      q;
    logic [PIX_W-1:0]      lim;
    twice_r = {drem_q[DIV_ST-1], dfrac_q[DIV_ST-1], 1'b0};
    den     = {1'b0, n_eff, FRAC_W'(0)};
    up      = (twice_r > den) || ((twice_r == den) && dword_q[DIV_ST-1][0]);
    q       = dword_q[DIV_ST-1] + QUO_W'(up);
    if (depth_q inside {[0:8]}) begin
      lim = LIM_D8;
    end else if (depth_q inside {[9:16]}) begin
      lim = LIM_D16;
    end else begin
      lim = LIM_WIDE;
    end
    if (q > QUO_W'(lim)) begin
      pix_d = lim;
    end else begin
      pix_d = q[PIX_W-1:0];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      terms_q <= terms_d;
    end
    if (ld[1]) begin
      psum_q <= psum_d;
    end
    if (ld[2]) begin
      sum_q <= sum_d;
    end
    if (ld[3]) begin
      gp_q <= GP_W'(gain_q) * GP_W'(sum_q);
      om_q <= OM_W'(offset_q) * OM_W'(maxval);
    end
    if (ld[4]) begin
      num_q <= num_d;
    end
    for (int k = 0; k < DIV_ST; k++) begin
      if (ld[ST_DIV0+k]) begin
        dword_q[k] <= dword_d[k];
        drem_q[k]  <= drem_d[k];
        if (k == 0) begin
          dfrac_q[k] <= num_q[FRAC_W-1:0];
        end else begin
          dfrac_q[k] <= dfrac_q[k-1];
        end
      end
    end
    if (ld[NUM_ST-1]) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o.valid       = vld_q[NUM_ST-1];
  assign pix_o.pixel_value = pix_q;

`ifndef SYNTHESIS
  // An accepted pixel word fills the first stage
  a_pix_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_acc && (cmd_i.command == CMD_PIXEL)) |=> vld_q[0])
    else $error("pixel word did not enter the pipeline");

  // A load word sets the register to the seed
  a_seed_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_acc && (cmd_i.command == CMD_LOAD)) |=> (lfsr_q == $past(cmd_i.seed_value)))
    else $error("seed not loaded");

  // After any advance the register is never all zero
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_acc && (cmd_i.command == CMD_PIXEL)) |=> (lfsr_q != '0))
    else $error("noise register stuck at zero");
`endif

endmodule

`default_nettype wire

@@ rtl/lnpg_lfsr_unroll.sv @@
// Unrolled register advances for one pixel: masked value after each
// advance and the register state after the last one. Uses lnpg_pkg.
`default_nettype none

module lnpg_lfsr_unroll (
  input  wire logic [lnpg_pkg::SEED_W-1:0] state_i,
  input  wire logic [lnpg_pkg::CNT_W-1:0]  count_i,
  input  wire logic [lnpg_pkg::PIX_W-1:0]  mask_i,
  output lnpg_pkg::term_vec_t              terms_o,
  output logic      [lnpg_pkg::SEED_W-1:0] next_o
);
  import lnpg_pkg::*;

  logic [MAX_ADV:0][SEED_W-1:0] chain;

  // Advance chain; terms past the count read as zero
  always_comb begin
    chain[0] = state_i;
    for (int i = 0; i < MAX_ADV; i++) begin
      chain[i+1] = lfsr_advance(chain[i]);
      if (CNT_W'(i) < count_i) begin
        terms_o[i] = chain[i+1][PIX_W-1:0] & mask_i;
      end else begin
        terms_o[i] = '0;
      end
    end
  end

  assign next_o = chain[count_i];

endmodule

`default_nettype wire
